[design/spmq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spmq_pkg
// Shared types and constants for the strict-priority multi-queue.
// ----------------------------------------------------------------------------
package spmq_pkg;

  localparam int PriorityLevels = 10;
  localparam int LevelDepth     = 16;
  localparam int PayloadWidth   = 32;

  typedef enum logic [1:0] {
    KIND_PUSH_ORD  = 2'd0,
    KIND_PUSH_PRIO = 2'd1,
    KIND_POP       = 2'd2,
    KIND_FIND      = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_PUSHED    = 3'd0,
    ST_POPPED    = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_FOUND     = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_POP_RD,
    BE_FIND_RD,
    BE_FIND_CMP,
    BE_RESULT
  } be_state_t;

endpackage : spmq_pkg
`default_nettype wire

[design/spmq_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spmq_front
// Accepts requests, reduces the priority to a queue index and holds them in
// a two-entry command queue for the back end.
// ----------------------------------------------------------------------------
module spmq_front
  import spmq_pkg::*;
#(
  parameter int PRIORITY_LEVELS = PriorityLevels,
  parameter int PAYLOAD_WIDTH   = PayloadWidth,
  parameter int QW              = $clog2(PRIORITY_LEVELS + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [1:0]               in_kind,
  input  wire logic [31:0]              in_payload,
  input  wire logic [7:0]               in_priority_req,
  output logic                          cmd_valid,
  input  wire logic                     cmd_ready,
  output kind_t                         cmd_kind,
  output logic [PAYLOAD_WIDTH-1:0]      cmd_word,
  output logic [QW-1:0]                 cmd_queue
);

  localparam int WordBits = (PAYLOAD_WIDTH < 32) ? PAYLOAD_WIDTH : 32;

  typedef struct packed {
    kind_t                    kind;
    logic [PAYLOAD_WIDTH-1:0] word;
    logic [QW-1:0]            queue;
  } cmd_t;

  cmd_t        q_r [2];
  cmd_t        enq;
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;
  logic [7:0]  prio_mod;
  logic [15:0] prio_rem;
  logic        push_en, pop_en;

  // Priority modulo level count: shift-and-subtract over the 8 request bits.
  always_comb begin
    prio_rem = 16'(in_priority_req);
    for (int s = 7; s >= 0; s--) begin
      if (prio_rem >= (16'(PRIORITY_LEVELS) << s)) begin
        prio_rem = prio_rem - (16'(PRIORITY_LEVELS) << s);
      end
    end
    prio_mod = prio_rem[7:0];
  end

  always_comb begin
    enq.kind = kind_t'(in_kind);
    enq.word = '0;
    enq.word[WordBits-1:0] = in_payload[WordBits-1:0];
    if (kind_t'(in_kind) == KIND_PUSH_PRIO) begin
      enq.queue = QW'(prio_mod);
    end else if (kind_t'(in_kind) == KIND_PUSH_ORD) begin
      enq.queue = QW'(PRIORITY_LEVELS);
    end else begin
      enq.queue = '0;
    end
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign push_en   = in_valid && in_ready;
  assign pop_en    = cmd_valid && cmd_ready;
  assign cmd_kind  = q_r[rd_ptr_r].kind;
  assign cmd_word  = q_r[rd_ptr_r].word;
  assign cmd_queue = q_r[rd_ptr_r].queue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_en) wr_ptr_r <= ~wr_ptr_r;
      if (pop_en)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push_en) - 2'(pop_en);
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) q_r[wr_ptr_r] <= enq;
  end

endmodule : spmq_front
`default_nettype wire

[design/spmq_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spmq_back
// Executes queue commands against the entry memory and per-queue pointers;
// owns the output register.
// ----------------------------------------------------------------------------
module spmq_back
  import spmq_pkg::*;
#(
  parameter int PRIORITY_LEVELS = PriorityLevels,
  parameter int LEVEL_DEPTH     = LevelDepth,
  parameter int PAYLOAD_WIDTH   = PayloadWidth,
  parameter int QW              = $clog2(PRIORITY_LEVELS + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cmd_valid,
  output logic                          cmd_ready,
  input  kind_t                         cmd_kind,
  input  wire logic [PAYLOAD_WIDTH-1:0] cmd_word,
  input  wire logic [QW-1:0]            cmd_queue,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [2:0]                    out_status,
  output logic [31:0]                   out_popped_payload,
  output logic [3:0]                    out_served_level,
  output logic                          out_not_empty
);

  localparam int QCount   = PRIORITY_LEVELS + 1;
  localparam int DW       = $clog2(LEVEL_DEPTH);
  localparam int CW       = $clog2(LEVEL_DEPTH + 1);
  localparam int AW       = $clog2(QCount * LEVEL_DEPTH);
  localparam int WordBits = (PAYLOAD_WIDTH < 32) ? PAYLOAD_WIDTH : 32;

  logic [PAYLOAD_WIDTH-1:0] mem [QCount * LEVEL_DEPTH];
  logic [PAYLOAD_WIDTH-1:0] rd_data_r;
  logic [DW-1:0]            head_r [QCount];
  logic [CW-1:0]            fill_r [QCount];

  be_state_t       state_r, state_nxt;
  logic [QW-1:0]   q_r, q_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [PAYLOAD_WIDTH-1:0] word_r, word_nxt;

  logic [2:0]      st_r, st_nxt;
  logic [31:0]     pop_r, pop_nxt;
  logic [3:0]      lvl_r, lvl_nxt;
  logic            ne_r, ne_nxt;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic            inc_en, dec_en;
  logic [QW-1:0]   ptr_q;
  logic            any_fill;
  logic [QW-1:0]   top_q;
  logic            top_found;

  function automatic logic [AW-1:0] slot(input logic [QW-1:0] q, input logic [DW-1:0] h,
                                         input logic [CW-1:0] off);
    logic [DW-1:0] s;
    s = DW'(CW'(h) + off);  // wraps modulo depth for power-of-two depth
    if (CW'(h) + off >= CW'(LEVEL_DEPTH)) s = DW'(CW'(h) + off - CW'(LEVEL_DEPTH));
    return AW'(q) * AW'(LEVEL_DEPTH) + AW'(s);
  endfunction

  // Highest non-empty queue for pop: levels high to low, ordinary last.
  always_comb begin
    top_found = 1'b0;
    top_q     = '0;
    any_fill  = 1'b0;
    for (int i = 0; i < QCount; i++) begin
      if (fill_r[i] != '0) any_fill = 1'b1;
    end
    if (fill_r[PRIORITY_LEVELS] != '0) begin
      top_found = 1'b1;
      top_q     = QW'(PRIORITY_LEVELS);
    end
    for (int i = 0; i < PRIORITY_LEVELS; i++) begin
      if (fill_r[i] != '0) begin
        top_found = 1'b1;
        top_q     = QW'(i);
      end
    end
  end

  assign out_valid          = (state_r == BE_RESULT);
  assign out_status         = st_r;
  assign out_popped_payload = pop_r;
  assign out_served_level   = lvl_r;
  assign out_not_empty      = ne_r;

  always_comb begin
    state_nxt = state_r;
    q_nxt     = q_r;
    idx_nxt   = idx_r;
    word_nxt  = word_r;
    st_nxt    = st_r;
    pop_nxt   = pop_r;
    lvl_nxt   = lvl_r;
    ne_nxt    = ne_r;
    cmd_ready = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = slot(cmd_queue, head_r[cmd_queue], fill_r[cmd_queue]);
    inc_en    = 1'b0;
    dec_en    = 1'b0;
    ptr_q     = cmd_queue;
    unique case (state_r)
      BE_IDLE: begin
        cmd_ready = cmd_valid;
        if (cmd_valid) begin
          pop_nxt  = '0;
          word_nxt = cmd_word;
          unique case (cmd_kind)
            KIND_PUSH_ORD, KIND_PUSH_PRIO: begin
              lvl_nxt = 4'(cmd_queue);
              if (fill_r[cmd_queue] >= CW'(LEVEL_DEPTH)) begin
                st_nxt = ST_FULL;
                ne_nxt = any_fill;
              end else begin
                wr_en  = 1'b1;
                inc_en = 1'b1;
                st_nxt = ST_PUSHED;
                ne_nxt = 1'b1;
              end
              state_nxt = BE_RESULT;
            end
            KIND_POP: begin
              if (!top_found) begin
                st_nxt    = ST_EMPTY;
                lvl_nxt   = '0;
                ne_nxt    = 1'b0;
                state_nxt = BE_RESULT;
              end else begin
                q_nxt     = top_q;
                rd_en     = 1'b1;
                rd_addr   = slot(top_q, head_r[top_q], '0);
                state_nxt = BE_POP_RD;
              end
            end
            KIND_FIND: begin
              q_nxt     = QW'(PRIORITY_LEVELS - 1);
              idx_nxt   = '0;
              state_nxt = BE_FIND_RD;
              if (PRIORITY_LEVELS == 0) q_nxt = QW'(PRIORITY_LEVELS);
            end
            default: ;
          endcase
        end
      end
      BE_POP_RD: begin
        ptr_q   = q_r;
        dec_en  = 1'b1;
        st_nxt  = ST_POPPED;
        lvl_nxt = 4'(q_r);
        pop_nxt = '0;
        pop_nxt[WordBits-1:0] = rd_data_r[WordBits-1:0];
        ne_nxt  = 1'b0;
        for (int i = 0; i < QCount; i++) begin
          if (QW'(i) == q_r) begin
            if (fill_r[i] > CW'(1)) ne_nxt = 1'b1;
          end else if (fill_r[i] != '0) begin
            ne_nxt = 1'b1;
          end
        end
        state_nxt = BE_RESULT;
      end
      BE_FIND_RD: begin
        // each entry read in BE_FIND_RD, compared in BE_FIND_CMP; walk queue q_r from oldest entry
        if (idx_r < fill_r[q_r]) begin
          rd_en     = 1'b1;
          rd_addr   = slot(q_r, head_r[q_r], idx_r);
          state_nxt = BE_FIND_CMP;
        end else if (q_r == QW'(PRIORITY_LEVELS)) begin
          st_nxt    = ST_NOT_FOUND;
          lvl_nxt   = '0;
          ne_nxt    = any_fill;
          state_nxt = BE_RESULT;
        end else begin
          idx_nxt = '0;
          q_nxt   = (q_r == '0) ? QW'(PRIORITY_LEVELS) : q_r - QW'(1);
        end
      end
      BE_FIND_CMP: begin
        if (rd_data_r == word_r) begin
          st_nxt    = ST_FOUND;
          lvl_nxt   = 4'(q_r);
          ne_nxt    = any_fill;
          state_nxt = BE_RESULT;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = BE_FIND_RD;
        end
      end
      BE_RESULT: begin
        if (out_ready) state_nxt = BE_IDLE;
      end
      default: state_nxt = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BE_IDLE;
      for (int i = 0; i < QCount; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (inc_en) fill_r[ptr_q] <= fill_r[ptr_q] + CW'(1);
      if (dec_en) begin
        fill_r[ptr_q] <= fill_r[ptr_q] - CW'(1);
        head_r[ptr_q] <= (head_r[ptr_q] == DW'(LEVEL_DEPTH - 1)) ? '0
                                                                 : head_r[ptr_q] + DW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r    <= q_nxt;
    idx_r  <= idx_nxt;
    word_r <= word_nxt;
    st_r   <= st_nxt;
    pop_r  <= pop_nxt;
    lvl_r  <= lvl_nxt;
    ne_r   <= ne_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= cmd_word;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

endmodule : spmq_back
`default_nettype wire

[design/strict_priority_multi_queue.sv]
`default_nettype none
// Push: result registered straight from BE_IDLE; pop: through BE_POP_RD (memory read).
// Find: each stored entry is read in BE_FIND_RD and compared in BE_FIND_CMP, queue by
// queue, one entry at a time from the entry memory. Back end takes no new request until its
// result leaves BE_RESULT; up to two requests queue ahead of it.
// Synchronous active-low reset empties every queue; the entry memory is not cleared.
// ----------------------------------------------------------------------------
// strict_priority_multi_queue
// Strict-priority FIFO set with an ordinary lowest-rank queue.
// ----------------------------------------------------------------------------
module strict_priority_multi_queue
  import spmq_pkg::*;
#(
  parameter int PRIORITY_LEVELS = PriorityLevels,
  parameter int LEVEL_DEPTH     = LevelDepth,
  parameter int PAYLOAD_WIDTH   = PayloadWidth
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [31:0] in_payload,
  input  wire logic [7:0]  in_priority_req,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [31:0]      out_popped_payload,
  output logic [3:0]       out_served_level,
  output logic             out_not_empty
);

  localparam int QW = $clog2(PRIORITY_LEVELS + 1);

  logic                     cmd_valid, cmd_ready;
  kind_t                    cmd_kind;
  logic [PAYLOAD_WIDTH-1:0] cmd_word;
  logic [QW-1:0]            cmd_queue;

  spmq_front #(
    .PRIORITY_LEVELS(PRIORITY_LEVELS),
    .PAYLOAD_WIDTH  (PAYLOAD_WIDTH),
    .QW             (QW)
  ) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_payload, .in_priority_req,
    .cmd_valid, .cmd_ready, .cmd_kind, .cmd_word, .cmd_queue
  );

  spmq_back #(
    .PRIORITY_LEVELS(PRIORITY_LEVELS),
    .LEVEL_DEPTH    (LEVEL_DEPTH),
    .PAYLOAD_WIDTH  (PAYLOAD_WIDTH),
    .QW             (QW)
  ) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd_kind, .cmd_word, .cmd_queue,
    .out_valid, .out_ready, .out_status, .out_popped_payload, .out_served_level,
    .out_not_empty
  );

endmodule : strict_priority_multi_queue
`default_nettype wire

[verif/spmq_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spmq_checker
// Watches both channels of the strict-priority multi-queue, keeps its own
// copy of the ten priority FIFOs and the ordinary FIFO, predicts each result
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module spmq_checker
  import spmq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [31:0] in_payload,
  input  wire logic [7:0]  in_priority_req,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [2:0]  out_status,
  input  wire logic [31:0] out_popped_payload,
  input  wire logic [3:0]  out_served_level,
  input  wire logic        out_not_empty,
  output int               fail_count,
  output int               pending
);

  localparam int QueueCount = PriorityLevels + 1;
  localparam int OrdinaryQ  = PriorityLevels;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] popped;
    logic [3:0]  level;
    logic        not_empty;
  } queue_result_t;

  logic [31:0] word_mem [QueueCount][LevelDepth];
  int          head_q [QueueCount];
  int          fill_q [QueueCount];
  queue_result_t expected_results [$];

  function automatic bit any_queue_filled();
    foreach (fill_q[q]) if (fill_q[q] != 0) return 1'b1;
    return 1'b0;
  endfunction

  task automatic predict_request(input logic [1:0] kind, input logic [31:0] word,
                                 input logic [7:0] prio);
    queue_result_t r;
    int q;
    bit hit;
    r = '{status: ST_EMPTY, popped: '0, level: '0, not_empty: 1'b0};
    case (kind_t'(kind))
      KIND_PUSH_ORD, KIND_PUSH_PRIO: begin
        q = (kind_t'(kind) == KIND_PUSH_ORD) ? OrdinaryQ : int'(prio) % PriorityLevels;
        r.level = q[3:0];
        if (fill_q[q] >= LevelDepth) begin
          r.status = ST_FULL;
        end else begin
          word_mem[q][(head_q[q] + fill_q[q]) % LevelDepth] = word;
          fill_q[q]++;
          r.status = ST_PUSHED;
        end
      end
      KIND_POP: begin
        for (int k = PriorityLevels; k >= 0; k--) begin
          q = (k == 0) ? OrdinaryQ : k - 1;
          if (fill_q[q] != 0) begin
            r.popped = word_mem[q][head_q[q]];
            head_q[q] = (head_q[q] + 1) % LevelDepth;
            fill_q[q]--;
            r.status = ST_POPPED;
            r.level = q[3:0];
            break;
          end
        end
      end
      default: begin
        hit = 1'b0;
        r.status = ST_NOT_FOUND;
        for (int k = PriorityLevels; k >= 0 && !hit; k--) begin
          q = (k == 0) ? OrdinaryQ : k - 1;
          for (int i = 0; i < fill_q[q]; i++)
            if (word_mem[q][(head_q[q] + i) % LevelDepth] == word) begin
              hit = 1'b1;
              r.status = ST_FOUND;
              r.level = q[3:0];
              break;
            end
        end
      end
    endcase
    r.not_empty = any_queue_filled();
    expected_results.push_back(r);
  endtask

  always @(posedge clk) begin
    queue_result_t e;
    if (!rst_n) begin
      foreach (fill_q[q]) begin
        fill_q[q] = 0;
        head_q[q] = 0;
      end
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result transaction: status %0d level %0d",
                     out_status, out_served_level);
        end else begin
          e = expected_results.pop_front();
          if (e.status !== out_status || e.popped !== out_popped_payload ||
              e.level !== out_served_level || e.not_empty !== out_not_empty) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp st %0d pl %h lv %0d ne %0d / got st %0d pl %h lv %0d ne %0d",
                       e.status, e.popped, e.level, e.not_empty, out_status,
                       out_popped_payload, out_served_level, out_not_empty);
          end
        end
      end
      // predict after the compare: a same-cycle result belongs to an older transaction
      if (in_valid && in_ready)
        predict_request(in_kind, in_payload, in_priority_req);
    end
    pending = expected_results.size();
  end

endmodule : spmq_checker

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the strict-priority multi-queue: directed corner
// cases, then random push/pop/find traffic under three idling profiles.
// ----------------------------------------------------------------------------
module testbench;
  import spmq_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  logic [31:0] in_payload;
  logic [7:0]  in_priority_req;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [31:0] out_popped_payload;
  logic [3:0]  out_served_level;
  logic        out_not_empty;
  int          fail_count;
  int          pending;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic [31:0] recent_words [8];

  localparam int CycleLimit = 3000000;

  strict_priority_multi_queue uut (.*);

  spmq_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // drive one transaction, then hold until accepted
  task automatic send_request(input kind_t kind, input logic [31:0] word,
                              input logic [7:0] prio);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_payload      <= word;
    in_priority_req <= prio;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    recent_words[$urandom_range(7)] = word;
  endtask

  task automatic random_request();
    int sel;
    logic [31:0] word;
    sel = $urandom_range(99);
    word = ($urandom_range(3) == 0) ? recent_words[$urandom_range(7)] : $urandom();
    if (sel < 30)      send_request(KIND_PUSH_PRIO, word, 8'($urandom_range(255)));
    else if (sel < 45) send_request(KIND_PUSH_ORD, word, 8'($urandom_range(255)));
    else if (sel < 80) send_request(KIND_POP, word, 8'($urandom_range(255)));
    else               send_request(KIND_FIND, word, 8'($urandom_range(255)));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = '0;
    in_payload = '0;
    in_priority_req = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (recent_words[i]) recent_words[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty pop, empty find, extremes, full level, ordering
    send_request(KIND_POP, 32'h0, 8'h0);
    send_request(KIND_FIND, 32'hFFFF_FFFF, 8'hFF);
    send_request(KIND_PUSH_PRIO, 32'hFFFF_FFFF, 8'hFF);
    send_request(KIND_PUSH_PRIO, 32'h0, 8'h0);
    send_request(KIND_PUSH_ORD, 32'hA5A5_5A5A, 8'h09);
    send_request(KIND_FIND, 32'hA5A5_5A5A, 8'h00);
    send_request(KIND_FIND, 32'h0, 8'h00);
    for (int i = 0; i < 17; i++)
      send_request(KIND_PUSH_PRIO, 32'h1000 + i, 8'd19);
    send_request(KIND_POP, 32'h0, 8'h0);
    drain_results();
    repeat (30) send_request(KIND_POP, 32'hFFFF_FFFF, 8'hFF);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 52 : 0;
      recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 13 : 0;
      for (int n = 0; n < 450; n++) begin
        random_request();
        if (n == 200) drain_results();
      end
      drain_results();
    end

    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule : testbench

[files.f]
design/spmq_pkg.sv
design/spmq_front.sv
design/spmq_back.sv
design/strict_priority_multi_queue.sv
verif/spmq_checker.sv
verif/testbench.sv
